[rtl/core/mspi_pkg.sv]
// Shared types, widths, codes and helpers of the multi-servo pose interpolator.
package mspi_pkg;

    localparam int MAX_SERVOS = 16;
    localparam int SLOT_W     = $clog2(MAX_SERVOS);
    localparam int CNT_W      = $clog2(MAX_SERVOS + 1);
    localparam int POS_SHIFT  = 3;
    localparam int ID_W       = 8;
    localparam int POS_W      = 10;
    localparam int SPOS_W     = POS_W + POS_SHIFT;
    localparam int STEP_W     = SPOS_W + 1;
    localparam int DUR_W      = 16;
    localparam int FLEN_W     = 8;
    localparam int ACT_W      = 5;
    localparam int OP_W       = 3;

    // Serial divider: dividend and divisor widths.
    localparam int DIV_W      = DUR_W;
    localparam int DEN_W      = DUR_W + 1;
    localparam int DCNT_W     = $clog2(DIV_W);

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_ADDR_W = 1;

    localparam logic [SPOS_W-1:0] RESET_POS = SPOS_W'(512) << POS_SHIFT;

    localparam logic [OP_W-1:0] OP_ASSIGN_ID   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_TARGET  = 3'd1;
    localparam logic [OP_W-1:0] OP_START       = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK        = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_CURRENT = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLEN   = 1'd1;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [SPOS_W-1:0] tgt;
        logic [SPOS_W-1:0] cur;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Contents of a slot that has not been written since reset.
    function automatic entry_t reset_entry(input logic [SLOT_W-1:0] a);
        entry_t e;
        e.id   = ID_W'(a) + ID_W'(1);
        e.cur  = RESET_POS;
        e.tgt  = RESET_POS;
        e.step = '0;
        return e;
    endfunction

endpackage

[rtl/core/multi_servo_pose_interpolator.sv]
// Top level of the multi-servo pose interpolator: slot memory and sequencer.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tuser op; s_tdata slot,id,position,dur
//  m_       | out       | m_tvalid/m_tready  | m_tdata id,position,still_moving; m_tlast
//  cfg_     | in        | cfg_we             | cfg_addr index, cfg_wdata value
//
// An assign-id or set-current item reads its slot and writes it back; a set-target item reads
// the slots in turn until the id matches. A start runs the serial divider for the frame count,
// then reads each active slot and divides for its step size; the divider is shared by the
// frame count and every step size. A frame tick updates the slots through the single memory
// port, then reads each slot again to give its result while the output is taken.
// Reset is synchronous and active low; it clears the control state and the per-slot valid
// bits, so no clearing pass runs. A stall on the result side holds the sequencer in place.
// The last result of a tick may wait in the output register while the next item is taken.
module multi_servo_pose_interpolator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // From bit 0: slot[4], servo_id[8], position[10], duration_ms[16], zero pad[2].
    input  logic [mspi_pkg::S_TDATA_W-1:0]      s_tdata,
    // op[3].
    input  logic [mspi_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // From bit 0: out_servo_id[8], out_position[10], still_moving[1], zero pad[5].
    output logic [mspi_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [mspi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mspi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_FDIV  = 3'd3;
    localparam logic [2:0] S_SDIV  = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OEMIT = 3'd6;

    // Slot memory: one word per slot, with a synchronous read registered in rd_q_reg.
    mspi_pkg::entry_t mem [mspi_pkg::MAX_SERVOS];
    mspi_pkg::entry_t rd_q_reg;
    logic             rd_vld_reg;
    logic [mspi_pkg::MAX_SERVOS-1:0] vld_reg;
    logic             rd_en;
    logic             mem_we;
    mspi_pkg::entry_t mem_wdata;

    logic [2:0] state_reg, state_next;
    logic [mspi_pkg::OP_W-1:0]     op_reg, op_next;
    logic [mspi_pkg::SLOT_W-1:0]   addr_reg, addr_next;
    logic [mspi_pkg::ID_W-1:0]     sid_reg, sid_next;
    logic [mspi_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [mspi_pkg::DEN_W-1:0]    frames_reg, frames_next;
    logic [mspi_pkg::CNT_W-1:0]    done_reg, done_next;
    logic                          moving_reg, moving_next;
    logic [mspi_pkg::ACT_W-1:0]    active_reg, active_next;
    logic [mspi_pkg::FLEN_W-1:0]   flen_reg, flen_next;

    logic [mspi_pkg::DEN_W-1:0]    div_rem_reg, div_rem_next;
    logic [mspi_pkg::DIV_W-1:0]    div_quo_reg, div_quo_next;
    logic [mspi_pkg::DEN_W-1:0]    div_den_reg, div_den_next;
    logic [mspi_pkg::DCNT_W-1:0]   div_cnt_reg, div_cnt_next;

    logic                          m_valid_reg, m_valid_next;
    logic [mspi_pkg::ID_W-1:0]     m_id_reg, m_id_next;
    logic [mspi_pkg::POS_W-1:0]    m_pos_reg, m_pos_next;
    logic                          m_mov_reg, m_mov_next;
    logic                          m_last_reg, m_last_next;

    // Input fields.
    logic [mspi_pkg::SLOT_W-1:0] in_slot;
    logic [mspi_pkg::ID_W-1:0]   in_sid;
    logic [mspi_pkg::POS_W-1:0]  in_pos;
    logic [mspi_pkg::DUR_W-1:0]  in_dur;

    assign in_slot = s_tdata[3:0];
    assign in_sid  = s_tdata[11:4];
    assign in_pos  = s_tdata[21:12];
    assign in_dur  = s_tdata[37:22];

    // Number of slots in the pose, clamped to the memory depth.
    logic [mspi_pkg::CNT_W-1:0] pose_n;
    logic                       last_slot;
    logic [mspi_pkg::FLEN_W-1:0] flen_eff;

    assign pose_n = (active_reg > mspi_pkg::ACT_W'(mspi_pkg::MAX_SERVOS))
                  ? mspi_pkg::CNT_W'(mspi_pkg::MAX_SERVOS)
                  : mspi_pkg::CNT_W'(active_reg);
    assign last_slot = (mspi_pkg::CNT_W'(addr_reg) + mspi_pkg::CNT_W'(1)) >= pose_n;
    assign flen_eff  = (flen_reg == '0) ? mspi_pkg::FLEN_W'(1) : flen_reg;

    // A slot that was never written reads as its reset contents.
    mspi_pkg::entry_t ent;
    assign ent = rd_vld_reg ? rd_q_reg : mspi_pkg::reset_entry(addr_reg);

    // Distance to target and the one-frame move.
    logic                         up;
    logic [mspi_pkg::SPOS_W-1:0]  span;
    logic                         hit;
    logic [mspi_pkg::SPOS_W-1:0]  new_cur;
    logic [mspi_pkg::STEP_W-1:0]  cur_plus;
    logic [mspi_pkg::STEP_W-1:0]  cur_minus;

    assign up        = ent.tgt > ent.cur;
    assign span      = up ? (ent.tgt - ent.cur) : (ent.cur - ent.tgt);
    assign cur_plus  = mspi_pkg::STEP_W'(ent.cur) + ent.step;
    assign cur_minus = mspi_pkg::STEP_W'(ent.cur) - ent.step;

    always_comb begin
        if (ent.cur == ent.tgt) begin
            hit     = 1'b1;
            new_cur = ent.cur;
        end else if (mspi_pkg::STEP_W'(span) < ent.step) begin
            hit     = 1'b1;
            new_cur = ent.tgt;
        end else begin
            hit     = 1'b0;
            new_cur = up ? cur_plus[mspi_pkg::SPOS_W-1:0] : cur_minus[mspi_pkg::SPOS_W-1:0];
        end
    end

    // One restoring division step per cycle.
    logic [mspi_pkg::DEN_W:0]   rem_sh;
    logic                       div_ge;
    logic [mspi_pkg::DEN_W:0]   rem_sub;
    logic [mspi_pkg::DEN_W-1:0] rem_new;
    logic [mspi_pkg::DIV_W-1:0] quo_new;
    logic                       div_fin;

    assign rem_sh  = {div_rem_reg, div_quo_reg[mspi_pkg::DIV_W-1]};
    assign div_ge  = rem_sh >= {1'b0, div_den_reg};
    assign rem_sub = rem_sh - {1'b0, div_den_reg};
    assign rem_new = div_ge ? rem_sub[mspi_pkg::DEN_W-1:0] : rem_sh[mspi_pkg::DEN_W-1:0];
    assign quo_new = {div_quo_reg[mspi_pkg::DIV_W-2:0], div_ge};
    assign div_fin = div_cnt_reg == mspi_pkg::DCNT_W'(mspi_pkg::DIV_W - 1);

    logic [mspi_pkg::CNT_W-1:0] done_sum;
    assign done_sum = done_reg + mspi_pkg::CNT_W'(hit);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        sid_next     = sid_reg;
        pos_next     = pos_reg;
        frames_next  = frames_reg;
        done_next    = done_reg;
        moving_next  = moving_reg;
        active_next  = active_reg;
        flen_next    = flen_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        m_valid_next = m_valid_reg;
        m_id_next    = m_id_reg;
        m_pos_next   = m_pos_reg;
        m_mov_next   = m_mov_reg;
        m_last_next  = m_last_reg;
        rd_en        = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = ent;

        if (cfg_we) begin
            case (cfg_addr)
                mspi_pkg::CFG_ACTIVE: active_next = cfg_wdata[mspi_pkg::ACT_W-1:0];
                mspi_pkg::CFG_FLEN:   flen_next   = cfg_wdata[mspi_pkg::FLEN_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    addr_next = in_slot;
                    sid_next  = in_sid;
                    pos_next  = in_pos;
                    case (s_tuser)
                        mspi_pkg::OP_ASSIGN_ID, mspi_pkg::OP_SET_CURRENT: begin
                            if (mspi_pkg::CNT_W'(in_slot) <
                                mspi_pkg::CNT_W'(mspi_pkg::MAX_SERVOS)) begin
                                state_next = S_RD;
                            end
                        end
                        mspi_pkg::OP_SET_TARGET: begin
                            addr_next = '0;
                            if (pose_n != '0) begin
                                state_next = S_RD;
                            end
                        end
                        mspi_pkg::OP_START: begin
                            div_rem_next = '0;
                            div_quo_next = in_dur;
                            div_den_next = mspi_pkg::DEN_W'(flen_eff);
                            div_cnt_next = '0;
                            state_next   = S_FDIV;
                        end
                        mspi_pkg::OP_TICK: begin
                            addr_next = '0;
                            done_next = '0;
                            if (moving_reg) begin
                                if (pose_n == '0) begin
                                    moving_next = 1'b0;
                                end else begin
                                    state_next = S_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_MOD;
            end

            S_MOD: begin
                case (op_reg)
                    mspi_pkg::OP_ASSIGN_ID: begin
                        mem_we       = 1'b1;
                        mem_wdata.id = sid_reg;
                        state_next   = S_IDLE;
                    end
                    mspi_pkg::OP_SET_CURRENT: begin
                        mem_we        = 1'b1;
                        mem_wdata.cur = mspi_pkg::SPOS_W'(pos_reg) << mspi_pkg::POS_SHIFT;
                        state_next    = S_IDLE;
                    end
                    mspi_pkg::OP_SET_TARGET: begin
                        if (ent.id == sid_reg) begin
                            mem_we        = 1'b1;
                            mem_wdata.tgt = mspi_pkg::SPOS_W'(pos_reg) << mspi_pkg::POS_SHIFT;
                            state_next    = S_IDLE;
                        end else if (last_slot) begin
                            state_next = S_IDLE;
                        end else begin
                            addr_next  = addr_reg + mspi_pkg::SLOT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    mspi_pkg::OP_START: begin
                        div_rem_next = '0;
                        div_quo_next = mspi_pkg::DIV_W'(span);
                        div_den_next = frames_reg;
                        div_cnt_next = '0;
                        state_next   = S_SDIV;
                    end
                    mspi_pkg::OP_TICK: begin
                        mem_we        = 1'b1;
                        mem_wdata.cur = new_cur;
                        if (last_slot) begin
                            moving_next = done_sum < pose_n;
                            addr_next   = '0;
                            state_next  = S_ORD;
                        end else begin
                            done_next  = done_sum;
                            addr_next  = addr_reg + mspi_pkg::SLOT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            S_FDIV: begin
                div_rem_next = rem_new;
                div_quo_next = quo_new;
                div_cnt_next = div_cnt_reg + mspi_pkg::DCNT_W'(1);
                if (div_fin) begin
                    frames_next = mspi_pkg::DEN_W'(quo_new) + mspi_pkg::DEN_W'(1);
                    addr_next   = '0;
                    if (pose_n == '0) begin
                        moving_next = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end

            S_SDIV: begin
                div_rem_next = rem_new;
                div_quo_next = quo_new;
                div_cnt_next = div_cnt_reg + mspi_pkg::DCNT_W'(1);
                if (div_fin) begin
                    mem_we         = 1'b1;
                    mem_wdata.step = mspi_pkg::STEP_W'(quo_new) + mspi_pkg::STEP_W'(1);
                    if (last_slot) begin
                        moving_next = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        addr_next  = addr_reg + mspi_pkg::SLOT_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            S_ORD: begin
                rd_en      = 1'b1;
                state_next = S_OEMIT;
            end

            S_OEMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_id_next    = ent.id;
                    m_pos_next   = ent.cur[mspi_pkg::SPOS_W-1:mspi_pkg::POS_SHIFT];
                    m_mov_next   = moving_reg;
                    m_last_next  = last_slot;
                    if (last_slot) begin
                        state_next = S_IDLE;
                    end else begin
                        addr_next  = addr_reg + mspi_pkg::SLOT_W'(1);
                        state_next = S_ORD;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        if (rd_en) begin
            rd_q_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            moving_reg  <= 1'b0;
            active_reg  <= mspi_pkg::ACT_W'(16);
            flen_reg    <= mspi_pkg::FLEN_W'(33);
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            moving_reg  <= moving_next;
            active_reg  <= active_next;
            flen_reg    <= flen_next;
            m_valid_reg <= m_valid_next;
            if (mem_we) begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[addr_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        sid_reg     <= sid_next;
        pos_reg     <= pos_next;
        frames_reg  <= frames_next;
        done_reg    <= done_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        m_id_reg    <= m_id_next;
        m_pos_reg   <= m_pos_next;
        m_mov_reg   <= m_mov_next;
        m_last_reg  <= m_last_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_mov_reg, m_pos_reg, m_id_reg};
    assign m_tlast  = m_last_reg;

endmodule

[rtl/core/mspi_checker.sv]
// Port-level checker of the multi-servo pose interpolator and its bind.
module mspi_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [mspi_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [mspi_pkg::OP_W-1:0]        s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mspi_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tlast
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An unused op does nothing, so the block is ready again at once.
    a_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser > mspi_pkg::OP_SET_CURRENT) |=> s_tready)
        else $error("unused op kept the block busy");

    // While a frame still has results to give, no new item is taken.
    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("item taken in the middle of a frame");

endmodule

bind multi_servo_pose_interpolator mspi_checker u_mspi_checker (.*);
